/* src/active_fault_code_set_macros.svh */
// ----------------------------------------------------------------------------
// active_fault_code_set_macros
// assertion helpers shared by the fault code set rtl
// ----------------------------------------------------------------------------
`ifndef ACTIVE_FAULT_CODE_SET_MACROS_SVH
`define ACTIVE_FAULT_CODE_SET_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define AFCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define AFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/afcs_pkg.sv */
// ----------------------------------------------------------------------------
// afcs_pkg
// shared types and codes of the active fault code set
// ----------------------------------------------------------------------------
`default_nettype none

package afcs_pkg;

  // operation codes
  localparam logic [1:0] KIND_RAISE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;
  localparam logic [1:0] KIND_LIST  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_PRESENT  = 3'd5;
  localparam logic [2:0] ST_ABSENT   = 3'd6;
  localparam logic [2:0] ST_LIST     = 3'd7;

  // most result items one list transaction gives
  localparam int MAX_RESULTS = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] fault_code;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] code_out;
    logic        entry_valid;
    logic [5:0]  active_count;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

/* src/afcs_ram.sv */
// ----------------------------------------------------------------------------
// afcs_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module afcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/afcs_engine.sv */
// ----------------------------------------------------------------------------
// afcs_engine
// sequencer that scans, updates and lists the code store one slot a cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "active_fault_code_set_macros.svh"

module afcs_engine #(
  parameter int CAPACITY = 32,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire afcs_pkg::cmd_t   cmd,
  output logic                  busy,
  output logic                  strobe,
  output afcs_pkg::result_t     result,
  // store ports
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [31:0]           wdata,
  output logic [AW-1:0]         raddr,
  input  wire logic [31:0]      rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_LIST
  } state_t;

  state_t      state;
  logic [1:0]  kind_q;
  logic [31:0] code_q;
  logic [AW-1:0] idx;
  logic [CW-1:0] count;

  logic [CW-1:0] count_m1;
  logic [CW-1:0] count_p1;
  logic [AW-1:0] idx_inc;
  logic          hit;
  logic          at_end;
  logic          list_last;
  logic          has_room;

  function automatic afcs_pkg::result_t mk(input logic [2:0] st, input logic [31:0] c,
                                          input logic v, input logic [CW-1:0] n,
                                          input logic l);
    afcs_pkg::result_t r;
    r.status       = st;
    r.code_out     = c;
    r.entry_valid  = v;
    r.active_count = 6'(n);
    r.last         = l;
    return r;
  endfunction

  assign count_m1  = count - 1'b1;
  assign count_p1  = CW'(count + 1'b1);
  assign idx_inc   = AW'(idx + 1'b1);
  assign hit       = (rdata == code_q);
  assign at_end    = (CW'(idx) == count_m1);
  assign list_last = at_end || (32'(idx) == afcs_pkg::MAX_RESULTS - 1);
  assign has_room  = (count < CW'(CAPACITY));
  assign busy      = (state != S_IDLE);

  // read address: next slot while scanning, last slot once a clear has hit
  always_comb begin
    raddr = '0;
    if (state == S_SCAN && hit) begin
      raddr = AW'(count_m1);
    end else if (state == S_SCAN || state == S_LIST) begin
      raddr = idx_inc;
    end
  end

  // write port: append on raise, fill the hole on clear
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = code_q;
    if (state == S_IDLE) begin
      we    = start && (cmd.kind == afcs_pkg::KIND_RAISE) && (count == '0);
      wdata = cmd.fault_code;
    end else if (state == S_SCAN) begin
      we    = !hit && at_end && (kind_q == afcs_pkg::KIND_RAISE) && has_room;
      waddr = AW'(count);
    end else if (state == S_MOVE) begin
      we    = 1'b1;
      waddr = idx;
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kind_q <= cmd.kind;
            code_q <= cmd.fault_code;
            idx    <= '0;
            if (count == '0) begin
              strobe <= 1'b1;
              unique case (cmd.kind)
                afcs_pkg::KIND_RAISE: begin
                  count  <= count_p1;
                  result <= mk(afcs_pkg::ST_ADDED, '0, 1'b0, count_p1, 1'b1);
                end
                afcs_pkg::KIND_CLEAR:
                  result <= mk(afcs_pkg::ST_NOTFOUND, '0, 1'b0, count, 1'b1);
                afcs_pkg::KIND_CHECK:
                  result <= mk(afcs_pkg::ST_ABSENT, '0, 1'b0, count, 1'b1);
                default:
                  result <= mk(afcs_pkg::ST_LIST, '0, 1'b0, count, 1'b1);
              endcase
            end else if (cmd.kind == afcs_pkg::KIND_LIST) begin
              state <= S_LIST;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            unique case (kind_q)
              afcs_pkg::KIND_RAISE: begin
                strobe <= 1'b1;
                state  <= S_IDLE;
                result <= mk(afcs_pkg::ST_DUP, '0, 1'b0, count, 1'b1);
              end
              afcs_pkg::KIND_CHECK: begin
                strobe <= 1'b1;
                state  <= S_IDLE;
                result <= mk(afcs_pkg::ST_PRESENT, '0, 1'b0, count, 1'b1);
              end
              default: begin
                if (at_end) begin
                  // hit on the last slot: nothing to move
                  strobe <= 1'b1;
                  state  <= S_IDLE;
                  count  <= count_m1;
                  result <= mk(afcs_pkg::ST_REMOVED, '0, 1'b0, count_m1, 1'b1);
                end else begin
                  state <= S_MOVE;
                end
              end
            endcase
          end else if (at_end) begin
            strobe <= 1'b1;
            state  <= S_IDLE;
            unique case (kind_q)
              afcs_pkg::KIND_RAISE: begin
                if (has_room) begin
                  count  <= count_p1;
                  result <= mk(afcs_pkg::ST_ADDED, '0, 1'b0, count_p1, 1'b1);
                end else begin
                  result <= mk(afcs_pkg::ST_FULL, '0, 1'b0, count, 1'b1);
                end
              end
              afcs_pkg::KIND_CLEAR:
                result <= mk(afcs_pkg::ST_NOTFOUND, '0, 1'b0, count, 1'b1);
              default:
                result <= mk(afcs_pkg::ST_ABSENT, '0, 1'b0, count, 1'b1);
            endcase
          end else begin
            idx <= idx_inc;
          end
        end
        S_MOVE: begin
          strobe <= 1'b1;
          state  <= S_IDLE;
          count  <= count_m1;
          result <= mk(afcs_pkg::ST_REMOVED, '0, 1'b0, count_m1, 1'b1);
        end
        S_LIST: begin
          strobe <= 1'b1;
          result <= mk(afcs_pkg::ST_LIST, rdata, 1'b1, count, list_last);
          if (list_last) begin
            state <= S_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AFCS_ASSERT_NOW(a_count_cap, 1'b1, count <= CW'(CAPACITY), "count above capacity")
  `AFCS_ASSERT_NOW(a_last_idle, strobe && result.last, !busy, "busy after final result")
  `AFCS_ASSERT_NOW(a_mid_busy, strobe && !result.last, busy, "idle inside a list")
  `AFCS_ASSERT_NOW(a_valid_list, strobe && result.entry_valid, result.status == afcs_pkg::ST_LIST, "valid code on non-list result")
  `AFCS_ASSERT_NEXT(a_accept_moves, start && !busy, busy || strobe, "accepted transaction dropped")

endmodule

`default_nettype wire

/* src/active_fault_code_set.sv */
// ----------------------------------------------------------------------------
// active_fault_code_set
// set of active fault codes with raise, clear, check and list transactions
// ----------------------------------------------------------------------------
// scan: raise, clear and check scan one slot per cycle from the store ram;
//   the result strobes once the scan hits or passes the last live slot, and
//   a clear that must move the last entry first writes it into the hole; list
//   gives one entry a cycle; an empty set answers without a scan
// throughput: one transaction at a time; busy holds off new ones while the
//   single read port of the store is walked one slot per cycle
// reset: rst empties the set at once; no clearing pass, only slots below the
//   live count are used; results are never stalled by the receiver
`default_nettype none

module active_fault_code_set #(
  parameter int CAPACITY = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // command side
  input  wire logic               start,
  input  wire afcs_pkg::cmd_t     cmd,
  output logic                    busy,
  // result side, one result item per strobe cycle
  output logic                    strobe,
  output afcs_pkg::result_t       result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // store port wiring between sequencer and code ram
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  // sequencer: scan compare, swap-remove and list walk
  afcs_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .result (result),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  // code store, slots 0 to count-1 are live
  afcs_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire
